@@ sv/cwb_pkg.sv @@
// Shared types and constants for the coalescing write buffer.
// Used by cwb_cell and coalescing_write_buffer_core; no dependencies.
package cwb_pkg;

    localparam int DISK_BLOCKS = 100;
    localparam int MAX_ENTRIES = 16;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_ERASE = 2'd2;
    localparam logic [1:0] REQ_FLUSH = 2'd3;

    localparam logic [2:0] ST_HIT    = 3'd0;
    localparam logic [2:0] ST_MISS   = 3'd1;
    localparam logic [2:0] ST_ENTRY  = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_REJECT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  block;
        logic [7:0]  count;
        logic [31:0] word;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  first_block;
        logic [7:0]  last_block;
        logic [31:0] value;
        logic        final_res;
    } out_t;

    typedef struct packed {
        logic [7:0]  first;
        logic [7:0]  last;
        logic [31:0] word;
    } entry_t;

    typedef struct packed {
        logic mark;
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

@@ sv/coalescing_write_buffer_core.sv @@
// Coalescing write buffer top level: request sequencer, output register, row of cells.
// Depends on cwb_pkg and cwb_cell.
//
// Usage: requests enter on in_valid/in_stall/in_data, results leave on
// out_valid/out_stall/out_data; a transfer happens when valid is high and
// stall is low. in_stall is low only while no request is in progress.
// A read or a rejected request gives one result, which passes from the request
// register through the output register. A write or erase takes a marking step,
// one compaction step per entry it drops (each drop shifts the cell row down by
// one) and an append step. A flush emits one entry per cycle from the oldest
// cell while the row shifts down, as long as the receiver does not stall;
// final_res marks the last result of a request.
// A stall holds the output register and the flush waits on it.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once; write them
// only while idle. Reset empties the buffer, clears the command count and
// sets erase value 0 and flush threshold 10.
module coalescing_write_buffer_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  cwb_pkg::in_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output cwb_pkg::out_t                     out_data,
    input  logic                              cfg_we,
    input  logic [cwb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cwb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RESP    = 3'd1;
    localparam logic [2:0] S_MARK    = 3'd2;
    localparam logic [2:0] S_COMPACT = 3'd3;
    localparam logic [2:0] S_FLUSH   = 3'd4;

    localparam int N = cwb_pkg::MAX_ENTRIES;
    localparam int CW = cwb_pkg::CNT_W;

    logic [2:0]            state_reg, state_next;
    cwb_pkg::in_t          req_reg, req_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [4:0]            cmd_reg, cmd_next;
    logic [31:0]           erase_value_reg;
    logic [4:0]            thr_reg;
    cwb_pkg::entry_t       new_reg, new_next;
    logic                  out_valid_reg, out_valid_next;
    cwb_pkg::out_t         out_reg, out_next;

    cwb_pkg::cell_ctrl_t   ctrl;
    cwb_pkg::entry_t       cell_ent [N];
    logic [N-1:0]          drop_vec, drop_pre, hit_vec, valid_vec, kill_vec;
    logic [N-1:0]          shift_sel, load_sel;
    cwb_pkg::entry_t       nbr_ent [N];
    logic [N-1:0]          nbr_drop;

    logic                  out_free, any_drop, rejected, hit_any, merged;
    logic [31:0]           hit_word, new_word;
    logic [8:0]            first9, last9, sum9, wide_first, wide_last;
    logic [CW-1:0]         count_inc;
    logic [4:0]            cmd_inc;
    logic [cwb_pkg::IDX_W-1:0] p_idx;
    cwb_pkg::entry_t       newest;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    // request decode
    assign rejected = ({1'b0, req_reg.block} >= 9'(cwb_pkg::DISK_BLOCKS))
                      || (req_reg.req_type == cwb_pkg::REQ_ERASE && req_reg.count == 8'd0);
    assign new_word = (req_reg.req_type == cwb_pkg::REQ_WRITE) ? req_reg.word : erase_value_reg;
    assign first9 = {1'b0, req_reg.block};
    assign sum9 = {1'b0, req_reg.block} + {1'b0, req_reg.count} - 9'd1;
    always_comb
    begin
        if (req_reg.req_type == cwb_pkg::REQ_WRITE)
        begin
            last9 = first9;
        end
        else if (sum9 > 9'(cwb_pkg::DISK_BLOCKS - 1))
        begin
            last9 = 9'(cwb_pkg::DISK_BLOCKS - 1);
        end
        else
        begin
            last9 = sum9;
        end
    end

    // merge with the newest entry
    assign p_idx = cwb_pkg::IDX_W'(count_reg - 1'b1);
    assign newest = cell_ent[p_idx];
    always_comb
    begin
        merged = 1'b0;
        wide_first = first9;
        wide_last = last9;
        if (count_reg != '0 && newest.word == new_word)
        begin
            if ({1'b0, newest.last} + 9'd1 == first9)
            begin
                merged = 1'b1;
                wide_first = {1'b0, newest.first};
            end
            else if (last9 + 9'd1 == {1'b0, newest.first})
            begin
                merged = 1'b1;
                wide_last = {1'b0, newest.last};
            end
        end
    end

    always_comb
    begin
        hit_any = 1'b0;
        hit_word = '0;
        for (int i = 0; i < N; i++)
        begin
            if (hit_vec[i])
            begin
                hit_any = 1'b1;
                hit_word = cell_ent[i].word;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            valid_vec[i] = (CW'(i) < count_reg);
            kill_vec[i] = merged && (cwb_pkg::IDX_W'(i) == p_idx);
            load_sel[i] = (CW'(i) == count_reg);
            drop_pre[i] = (i == 0) ? drop_vec[0] : (drop_vec[i] || drop_pre[i-1]);
            shift_sel[i] = (state_reg == S_FLUSH) || drop_pre[i];
        end
    end
    assign any_drop = drop_pre[N-1];

    assign ctrl.mark  = (state_reg == S_MARK);
    assign ctrl.shift = (state_reg == S_COMPACT && any_drop)
                        || (state_reg == S_FLUSH && out_free && count_reg != '0);
    assign ctrl.load  = (state_reg == S_COMPACT) && !any_drop && (count_reg < CW'(N));

    assign count_inc = count_reg + 1'b1;
    assign cmd_inc = (cmd_reg == 5'd31) ? cmd_reg : cmd_reg + 5'd1;

    always_comb
    begin
        state_next = state_reg;
        req_next = req_reg;
        count_next = count_reg;
        cmd_next = cmd_reg;
        new_next = new_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = in_data;
                    if (in_data.req_type == cwb_pkg::REQ_FLUSH)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP:
            begin
                if (!rejected && req_reg.req_type != cwb_pkg::REQ_READ)
                begin
                    state_next = S_MARK;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.first_block = req_reg.block;
                    out_next.last_block = req_reg.block;
                    out_next.final_res = 1'b1;
                    out_next.value = '0;
                    if (rejected)
                    begin
                        out_next.status = cwb_pkg::ST_REJECT;
                    end
                    else if (hit_any)
                    begin
                        out_next.status = cwb_pkg::ST_HIT;
                        out_next.value = hit_word;
                    end
                    else
                    begin
                        out_next.status = cwb_pkg::ST_MISS;
                    end
                    state_next = S_IDLE;
                end
            end
            S_MARK:
            begin
                new_next.first = wide_first[7:0];
                new_next.last = wide_last[7:0];
                new_next.word = new_word;
                state_next = S_COMPACT;
            end
            S_COMPACT:
            begin
                if (any_drop)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    if (count_reg < CW'(N))
                    begin
                        count_next = count_inc;
                    end
                    cmd_next = cmd_inc;
                    if (cmd_inc >= thr_reg || count_inc >= CW'(N))
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        out_next.status = cwb_pkg::ST_EMPTY;
                        out_next.first_block = '0;
                        out_next.last_block = '0;
                        out_next.value = '0;
                        out_next.final_res = 1'b1;
                        cmd_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        out_next.status = cwb_pkg::ST_ENTRY;
                        out_next.first_block = cell_ent[0].first;
                        out_next.last_block = cell_ent[0].last;
                        out_next.value = cell_ent[0].word;
                        out_next.final_res = (count_reg == CW'(1));
                        count_next = count_reg - 1'b1;
                        if (count_reg == CW'(1))
                        begin
                            cmd_next = '0;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cmd_reg <= '0;
            out_valid_reg <= 1'b0;
            erase_value_reg <= '0;
            thr_reg <= 5'd10;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cmd_reg <= cmd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == cwb_pkg::CFG_ERASE_VALUE)
            begin
                erase_value_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == cwb_pkg::CFG_THRESHOLD)
            begin
                thr_reg <= cfg_data[4:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        new_reg <= new_next;
        out_reg <= out_next;
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            if (g == N - 1)
            begin : g_top
                assign nbr_ent[g] = '0;
                assign nbr_drop[g] = 1'b0;
            end
            else
            begin : g_mid
                assign nbr_ent[g] = cell_ent[g+1];
                assign nbr_drop[g] = drop_vec[g+1];
            end
            cwb_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .shift_sel  (shift_sel[g]),
                .load_sel   (load_sel[g]),
                .valid      (valid_vec[g]),
                .merge_kill (kill_vec[g]),
                .cmp_first  (wide_first),
                .cmp_last   (wide_last),
                .rd_block   (req_reg.block),
                .new_entry  (new_reg),
                .nbr_entry  (nbr_ent[g]),
                .nbr_drop   (nbr_drop[g]),
                .entry      (cell_ent[g]),
                .drop       (drop_vec[g]),
                .hit        (hit_vec[g])
            );
        end
    endgenerate

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(N))
        else $error("entry count above capacity");

    a_flush_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && out_free && count_reg != '0)
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("flush did not retire one entry");

    a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == cwb_pkg::ST_EMPTY) |-> out_data.final_res)
        else $error("empty flush result not marked final");

endmodule

@@ sv/cwb_cell.sv @@
// One buffer slot: holds an entry and its drop mark, shifts from its upper neighbor.
// Depends on cwb_pkg.
module cwb_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  cwb_pkg::cell_ctrl_t ctrl,
    input  logic                shift_sel,
    input  logic                load_sel,
    input  logic                valid,
    input  logic                merge_kill,
    input  logic [8:0]          cmp_first,
    input  logic [8:0]          cmp_last,
    input  logic [7:0]          rd_block,
    input  cwb_pkg::entry_t     new_entry,
    input  cwb_pkg::entry_t     nbr_entry,
    input  logic                nbr_drop,
    output cwb_pkg::entry_t     entry,
    output logic                drop,
    output logic                hit
);

    cwb_pkg::entry_t entry_reg;
    logic            drop_reg;
    logic            covered;

    assign covered = (cmp_first <= {1'b0, entry_reg.first})
                     && ({1'b0, entry_reg.last} <= cmp_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg <= 1'b0;
        end
        else if (ctrl.shift && shift_sel)
        begin
            drop_reg <= nbr_drop;
        end
        else if (ctrl.mark)
        begin
            drop_reg <= valid && (merge_kill || covered);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift && shift_sel)
        begin
            entry_reg <= nbr_entry;
        end
        else if (ctrl.load && load_sel)
        begin
            entry_reg <= new_entry;
        end
    end

    assign entry = entry_reg;
    assign drop  = drop_reg;
    assign hit   = valid && (entry_reg.first <= rd_block) && (rd_block <= entry_reg.last);

endmodule

@@ tb/tb_coalescing_write_buffer_core.sv @@
// Self-checking testbench for coalescing_write_buffer_core: predicts every result of
// each request transfer with an in-line buffer model and compares the whole result.
// Depends on cwb_pkg and the RTL of coalescing_write_buffer_core.
module tb_coalescing_write_buffer_core;

    // register indexes with no register behind them
    localparam logic [cwb_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [cwb_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    cwb_pkg::in_t in_data;
    logic out_valid;
    logic out_stall;
    cwb_pkg::out_t out_data;
    logic cfg_we;
    logic [cwb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cwb_pkg::CFG_DATA_W-1:0] cfg_data;

    coalescing_write_buffer_core dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // buffer model state
    int ent_first[cwb_pkg::MAX_ENTRIES];
    int ent_last[cwb_pkg::MAX_ENTRIES];
    logic [31:0] ent_word[cwb_pkg::MAX_ENTRIES];
    int ent_n;
    int cmd_n;
    logic [31:0] erase_word;
    int flush_level;

    cwb_pkg::in_t pending_reqs[$];
    cwb_pkg::out_t expected_results[$];
    int errors;
    int mismatches;
    bit no_idle;
    bit hold_off_req;
    bit tx_taken;
    int tx_gap;
    int rx_wait;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic cwb_pkg::out_t make_result(logic [2:0] st, int fb, int lb,
                                                  logic [31:0] v, bit fin);
        cwb_pkg::out_t r;
        r.status = st;
        r.first_block = fb[7:0];
        r.last_block = lb[7:0];
        r.value = v;
        r.final_res = fin;
        return r;
    endfunction

    function automatic void expect_result(cwb_pkg::out_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic void flush_buffer();
        if (ent_n == 0)
            expect_result(make_result(cwb_pkg::ST_EMPTY, 0, 0, 0, 1'b1));
        for (int i = 0; i < ent_n; i++)
            expect_result(make_result(cwb_pkg::ST_ENTRY, ent_first[i], ent_last[i],
                                      ent_word[i], i == ent_n - 1));
        ent_n = 0;
        cmd_n = 0;
    endfunction

    function automatic void add_range(int fb, int lb, logic [31:0] w);
        bit keep[cwb_pkg::MAX_ENTRIES];
        int k;
        int p;
        k = 0;
        if (ent_n > 0)
        begin
            p = ent_n - 1;
            for (int i = 0; i < ent_n; i++)
                keep[i] = 1'b1;
            // merge with the newest entry when ranges touch and data matches
            if (ent_word[p] == w)
            begin
                if (ent_last[p] + 1 == fb)
                begin
                    fb = ent_first[p];
                    keep[p] = 1'b0;
                end
                else if (lb + 1 == ent_first[p])
                begin
                    lb = ent_last[p];
                    keep[p] = 1'b0;
                end
            end
            for (int i = 0; i < ent_n; i++)
                if (fb <= ent_first[i] && ent_last[i] <= lb)
                    keep[i] = 1'b0;
            for (int i = 0; i < ent_n; i++)
                if (keep[i])
                begin
                    ent_first[k] = ent_first[i];
                    ent_last[k] = ent_last[i];
                    ent_word[k] = ent_word[i];
                    k++;
                end
        end
        if (k < cwb_pkg::MAX_ENTRIES)
        begin
            ent_first[k] = fb;
            ent_last[k] = lb;
            ent_word[k] = w;
            k++;
        end
        ent_n = k;
    endfunction

    function automatic void model_request(cwb_pkg::in_t x);
        int blk;
        int lb;
        blk = x.block;
        if (x.req_type == cwb_pkg::REQ_FLUSH)
        begin
            flush_buffer();
            return;
        end
        if (blk >= cwb_pkg::DISK_BLOCKS || (x.req_type == cwb_pkg::REQ_ERASE && x.count == 0))
        begin
            expect_result(make_result(cwb_pkg::ST_REJECT, blk, blk, 0, 1'b1));
            return;
        end
        if (x.req_type == cwb_pkg::REQ_READ)
        begin
            for (int j = ent_n - 1; j >= 0; j--)
                if (ent_first[j] <= blk && blk <= ent_last[j])
                begin
                    expect_result(make_result(cwb_pkg::ST_HIT, blk, blk, ent_word[j], 1'b1));
                    return;
                end
            expect_result(make_result(cwb_pkg::ST_MISS, blk, blk, 0, 1'b1));
            return;
        end
        if (x.req_type == cwb_pkg::REQ_WRITE)
            add_range(blk, blk, x.word);
        else
        begin
            lb = blk + x.count - 1;
            if (lb > cwb_pkg::DISK_BLOCKS - 1)
                lb = cwb_pkg::DISK_BLOCKS - 1;
            add_range(blk, lb, erase_word);
        end
        if (cmd_n < 31)
            cmd_n++;
        if (cmd_n >= flush_level || ent_n >= cwb_pkg::MAX_ENTRIES)
            flush_buffer();
    endfunction

    // request driver
    always @(negedge clk)
    begin
        logic nv;
        if (rst_n && !(in_valid && !tx_taken))
        begin
            tx_taken = 1'b0;
            nv = 1'b0;
            if (tx_gap > 0)
                tx_gap--;
            else if (pending_reqs.size() > 0)
            begin
                nv = 1'b1;
                in_data <= pending_reqs.pop_front();
                tx_gap = draw_wait();
            end
            in_valid <= nv;
        end
    end

    // result receiver; a hold-off request stalls for a long stretch
    always @(negedge clk)
    begin
        if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            rx_wait = 150;
        end
        if (rx_wait > 0)
        begin
            rx_wait--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // monitor: predict on request transfer, check on result transfer
    always @(posedge clk)
    begin
        cwb_pkg::out_t e;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                model_request(in_data);
                tx_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                rx_wait = draw_wait();
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected result %p", out_data);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (out_data !== e)
                    begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("mismatch: expected %p got %p", e, out_data);
                    end
                end
            end
        end
    end

    task automatic push_req(logic [1:0] t, int blk, int cnt, logic [31:0] w);
        cwb_pkg::in_t x;
        x.req_type = t;
        x.block = blk[7:0];
        x.count = cnt[7:0];
        x.word = w;
        pending_reqs = {pending_reqs, x};
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        // a write or erase can still be busy with no result pending
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [cwb_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        if (idx == cwb_pkg::CFG_ERASE_VALUE)
            erase_word = d;
        else if (idx == cwb_pkg::CFG_THRESHOLD)
            flush_level = d[4:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_req(logic [31:0] pool0, logic [31:0] pool1);
        int r;
        int blk;
        logic [31:0] w;
        r = $urandom_range(0, 99);
        blk = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: w = pool0;
            1: w = pool1;
            default: w = $urandom();
        endcase
        if (r < 30)
            push_req(cwb_pkg::REQ_READ, blk, $urandom_range(0, 255), $urandom());
        else if (r < 65)
            push_req(cwb_pkg::REQ_WRITE, blk, $urandom_range(0, 255), w);
        else if (r < 92)
            push_req(cwb_pkg::REQ_ERASE, blk,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(1, 8),
                     $urandom());
        else
            push_req(cwb_pkg::REQ_FLUSH, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom());
    endtask

    initial
    begin
        logic [31:0] ev;
        int lvl;
        errors = 0;
        mismatches = 0;
        no_idle = 1'b0;
        hold_off_req = 1'b0;
        tx_taken = 1'b0;
        tx_gap = 0;
        rx_wait = 0;
        ent_n = 0;
        cmd_n = 0;
        erase_word = 0;
        flush_level = 10;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed part: extremes, rejects, clamp, merges and drops
        write_reg(cwb_pkg::CFG_THRESHOLD, 16);
        write_reg(cwb_pkg::CFG_ERASE_VALUE, 32'hFFFF_FFFF);
        push_req(cwb_pkg::REQ_FLUSH, 255, 255, 32'hFFFF_FFFF);
        push_req(cwb_pkg::REQ_READ, 0, 1, 0);
        push_req(cwb_pkg::REQ_WRITE, 0, 1, 32'h0000_0000);
        push_req(cwb_pkg::REQ_WRITE, 1, 1, 32'h0000_0000);
        push_req(cwb_pkg::REQ_READ, 1, 1, 0);
        push_req(cwb_pkg::REQ_READ, 99, 1, 0);
        push_req(cwb_pkg::REQ_READ, 100, 1, 0);
        push_req(cwb_pkg::REQ_READ, 255, 1, 0);
        push_req(cwb_pkg::REQ_WRITE, 255, 1, 32'h1234_5678);
        push_req(cwb_pkg::REQ_ERASE, 10, 0, 0);
        push_req(cwb_pkg::REQ_ERASE, 95, 255, 0);
        push_req(cwb_pkg::REQ_WRITE, 94, 1, 32'hFFFF_FFFF);
        push_req(cwb_pkg::REQ_READ, 99, 1, 0);
        push_req(cwb_pkg::REQ_WRITE, 50, 1, 32'hA5A5_5A5A);
        push_req(cwb_pkg::REQ_WRITE, 49, 1, 32'hA5A5_5A5A);
        push_req(cwb_pkg::REQ_WRITE, 52, 1, 32'h5A5A_A5A5);
        push_req(cwb_pkg::REQ_ERASE, 40, 20, 0);
        push_req(cwb_pkg::REQ_READ, 50, 1, 0);
        push_req(cwb_pkg::REQ_FLUSH, 0, 0, 0);
        push_req(cwb_pkg::REQ_FLUSH, 0, 0, 0);
        wait_idle();

        write_reg(CFG_SPARE_LO, 32'hDEAD_BEEF);
        write_reg(CFG_SPARE_HI, 32'h0000_0001);
        write_reg(cwb_pkg::CFG_THRESHOLD, 1);
        write_reg(cwb_pkg::CFG_ERASE_VALUE, 32'h0000_0000);
        for (int i = 0; i < 10; i++)
            random_req(32'h0, 32'h1);
        wait_idle();

        // fill the buffer while results back up
        write_reg(cwb_pkg::CFG_THRESHOLD, 16);
        hold_off_req = 1'b1;
        for (int i = 0; i < 40; i++)
            push_req(cwb_pkg::REQ_WRITE, (i * 7) % 100, 1, $urandom());
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: lvl = 1;
                1: lvl = 16;
                2: lvl = 10;
                default: lvl = $urandom_range(1, 16);
            endcase
            ev = (ph == 1) ? 32'hFFFF_FFFF : $urandom();
            write_reg(cwb_pkg::CFG_THRESHOLD, lvl);
            write_reg(cwb_pkg::CFG_ERASE_VALUE, ev);
            no_idle = ph[0];
            for (int i = 0; i < 60; i++)
                random_req(ev, 32'h0000_00FF);
            wait_idle();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule
